// ===== rtl/rgb565_five_four_upscaler_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef RGB565_FIVE_FOUR_UPSCALER_MACROS_SVH
`define RGB565_FIVE_FOUR_UPSCALER_MACROS_SVH

// checked on every rising edge outside reset
`define RGBUP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define RGBUP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/rgbup_pkg.sv =====
package rgbup_pkg;

    // frame geometry
    localparam int GROUPS_PER_LINE = 64;
    localparam int DEST_ROWS       = 240;

    // pixel and field widths
    localparam int PIX_W     = 16;
    localparam int ROW_OUT_W = 8;
    localparam int GRP_OUT_W = 6;

    // counters wide enough for any geometry, never narrower than the reported fields
    localparam int GRP_CLOG  = (GROUPS_PER_LINE > 1) ? $clog2(GROUPS_PER_LINE) : 1;
    localparam int GRP_CNT_W = (GRP_CLOG > GRP_OUT_W) ? GRP_CLOG : GRP_OUT_W;
    localparam int ROW_CLOG  = $clog2(DEST_ROWS + 2);
    localparam int ROW_CNT_W = (ROW_CLOG > ROW_OUT_W) ? ROW_CLOG : ROW_OUT_W;

    // stream widths: four pixels in, five pixels plus row and group out
    localparam int IN_DATA_W  = 4 * PIX_W;
    localparam int OUT_USED_W = 5 * PIX_W + ROW_OUT_W + GRP_OUT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // source line phase that is written to two destination rows
    localparam logic [1:0] PHASE_REPEAT = 2'd3;

    // per-channel halving mask for rgb565
    localparam logic [PIX_W-1:0] BLEND_MASK = 16'hf7de;

    // queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // one classified group waiting for the back end
    typedef struct packed {
        logic [PIX_W-1:0]     pix_a;
        logic [PIX_W-1:0]     blend;
        logic [PIX_W-1:0]     pix_b;
        logic [PIX_W-1:0]     pix_c;
        logic [PIX_W-1:0]     pix_d;
        logic [ROW_OUT_W-1:0] row;
        logic [GRP_OUT_W-1:0] grp;
        logic                 twice;
    } t_entry;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // rounded-down average of each colour channel
    function automatic logic [PIX_W-1:0] blend565(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        blend565 = (((a ^ b) & BLEND_MASK) >> 1) + (a & b);
    endfunction

endpackage

// ===== rtl/rgb565_five_four_upscaler.sv =====
// rgb565 5/4 upscaler
// slave channel: one beat carries four consecutive source pixels of a line,
// first pixel in the lowest bits. master channel: one beat carries five
// destination pixels (first, blend of first and second, second, third,
// fourth) with their destination row and group; tlast marks the final beat
// that a source group causes.
// an accepted source beat is written into the queue and then loaded into
// the output register that drives tvalid.
// throughput: one group per cycle on ordinary lines while the receiver
// is ready; on every fourth source line each group gives two beats, so
// the master side falls behind there and the two-entry queue fills and
// throttles the slave side.
// reset (synchronous, active low) clears the group, row and line phase
// counters, empties the queue and drops tvalid; the next group starts a frame.
// a stalled receiver holds the output register; the queue keeps accepting
// until both entries are taken, then tready falls.
module rgb565_five_four_upscaler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // fields from bit 0: pixel_a, pixel_b, pixel_c, pixel_d
    input  logic [rgbup_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // fields from bit 0: out_first, out_blend, out_second, out_third,
    // out_fourth, dest_row, dest_group, zero pad
    output logic [rgbup_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // run_last
    output logic                             o_m_tlast
);

    rgbup_pkg::t_entry        push_entry;
    rgbup_pkg::t_entry        head_entry;
    rgbup_pkg::t_queue_status queue_status;
    logic                     push;
    logic                     pop;

    // accept and classify
    rgbup_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_full  (queue_status.full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // decoupling queue
    rgbup_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_status (queue_status),
        .o_head   (head_entry)
    );

    // emit one or two rows per group
    rgbup_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (queue_status),
        .i_head   (head_entry),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .o_data   (o_m_tdata),
        .o_last   (o_m_tlast),
        .i_ready  (i_m_tready)
    );

endmodule

// ===== rtl/rgbup_front.sv =====
`include "rgb565_five_four_upscaler_macros.svh"

module rgbup_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [rgbup_pkg::IN_DATA_W-1:0] i_data,
    input  logic                            i_full,
    output logic                            o_ready,
    output logic                            o_push,
    output rgbup_pkg::t_entry               o_entry
);

    localparam logic [rgbup_pkg::GRP_CNT_W-1:0] GRP_LAST =
        rgbup_pkg::GRP_CNT_W'(rgbup_pkg::GROUPS_PER_LINE - 1);
    localparam logic [rgbup_pkg::ROW_CNT_W-1:0] ROW_LIMIT =
        rgbup_pkg::ROW_CNT_W'(rgbup_pkg::DEST_ROWS);

    logic [rgbup_pkg::GRP_CNT_W-1:0] r_group, n_group;
    logic [rgbup_pkg::ROW_CNT_W-1:0] r_row, n_row;
    logic [1:0]                      r_phase, n_phase;

    logic                            accept;
    logic                            repeat_line;
    logic [rgbup_pkg::ROW_CNT_W-1:0] row_step;
    logic [rgbup_pkg::PIX_W-1:0]     pix_a, pix_b, pix_c, pix_d;

    // unpack the group, first pixel lowest
    assign pix_a = i_data[0 +: rgbup_pkg::PIX_W];
    assign pix_b = i_data[rgbup_pkg::PIX_W +: rgbup_pkg::PIX_W];
    assign pix_c = i_data[2*rgbup_pkg::PIX_W +: rgbup_pkg::PIX_W];
    assign pix_d = i_data[3*rgbup_pkg::PIX_W +: rgbup_pkg::PIX_W];

    assign o_ready     = !i_full;
    assign accept      = i_valid && !i_full;
    assign o_push      = accept;
    assign repeat_line = (r_phase == rgbup_pkg::PHASE_REPEAT);

    // classify the beat: blend, position and whether it goes to two rows
    always_comb begin
        o_entry.pix_a = pix_a;
        o_entry.blend = rgbup_pkg::blend565(pix_a, pix_b);
        o_entry.pix_b = pix_b;
        o_entry.pix_c = pix_c;
        o_entry.pix_d = pix_d;
        o_entry.row   = r_row[rgbup_pkg::ROW_OUT_W-1:0];
        o_entry.grp   = r_group[rgbup_pkg::GRP_OUT_W-1:0];
        o_entry.twice = repeat_line &&
                        ((r_row + rgbup_pkg::ROW_CNT_W'(1)) < ROW_LIMIT);
    end

    // group, row and line phase counters
    always_comb begin
        n_group  = r_group;
        n_row    = r_row;
        n_phase  = r_phase;
        row_step = r_row + (repeat_line ? rgbup_pkg::ROW_CNT_W'(2)
                                        : rgbup_pkg::ROW_CNT_W'(1));
        if (accept) begin
            if (r_group == GRP_LAST) begin
                n_group = '0;
                if (row_step >= ROW_LIMIT) begin
                    n_row   = '0;
                    n_phase = '0;
                end else begin
                    n_row   = row_step;
                    n_phase = r_phase + 2'd1;
                end
            end else begin
                n_group = r_group + rgbup_pkg::GRP_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else begin
            r_group <= n_group;
            r_row   <= n_row;
            r_phase <= n_phase;
        end
    end

    // counters stay inside the frame
    `RGBUP_ASSERT(a_group_range, (r_group <= GRP_LAST), "group counter past end of line")
    `RGBUP_ASSERT(a_row_range, (r_row < ROW_LIMIT), "row counter past end of frame")

endmodule

// ===== rtl/rgbup_queue.sv =====
module rgbup_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  rgbup_pkg::t_entry        i_entry,
    input  logic                     i_pop,
    output rgbup_pkg::t_queue_status o_status,
    output rgbup_pkg::t_entry        o_head
);

    rgbup_pkg::t_entry                 r_slot [rgbup_pkg::QUEUE_DEPTH];
    logic [rgbup_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [rgbup_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [rgbup_pkg::QUEUE_CNT_W-1:0] r_count, n_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == rgbup_pkg::QUEUE_CNT_W'(rgbup_pkg::QUEUE_DEPTH));
    assign o_head         = r_slot[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + rgbup_pkg::QUEUE_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - rgbup_pkg::QUEUE_CNT_W'(1);
        end
    end

    // pointers wrap naturally as the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + rgbup_pkg::QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + rgbup_pkg::QUEUE_PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== rtl/rgbup_back.sv =====
`include "rgb565_five_four_upscaler_macros.svh"

module rgbup_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rgbup_pkg::t_queue_status         i_status,
    input  rgbup_pkg::t_entry                i_head,
    output logic                             o_pop,
    output logic                             o_valid,
    output logic [rgbup_pkg::OUT_DATA_W-1:0] o_data,
    output logic                             o_last,
    input  logic                             i_ready
);

    logic                             r_valid, n_valid;
    logic                             r_second, n_second;
    logic [rgbup_pkg::OUT_DATA_W-1:0] r_data, n_data;
    logic                             r_last, n_last;

    logic                             load;
    logic [rgbup_pkg::ROW_OUT_W-1:0]  row_sel;

    assign load    = !i_status.empty && (!r_valid || i_ready);
    assign row_sel = r_second ? (i_head.row + rgbup_pkg::ROW_OUT_W'(1)) : i_head.row;

    // output register: first row, then the repeated row when the entry asks for it
    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_data   = r_data;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (load) begin
            n_valid  = 1'b1;
            n_data   = {{rgbup_pkg::OUT_PAD_W{1'b0}}, i_head.grp, row_sel,
                        i_head.pix_d, i_head.pix_c, i_head.pix_b,
                        i_head.blend, i_head.pix_a};
            n_second = i_head.twice && !r_second;
            n_last   = !n_second;
            o_pop    = !n_second;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    // a pending repeated row keeps its entry at the head of the queue
    `RGBUP_ASSERT(a_second_held, r_second |-> (!i_status.empty && i_head.twice), "repeated row lost its entry")
    // the repeated row follows its first row straight away
    `RGBUP_ASSERT(a_pair_adjacent, (o_valid && i_ready && !o_last) |=> (o_valid && o_last), "repeated row not ready after first row")

endmodule

// ===== test/rgb565_five_four_upscaler_checker.sv =====
`timescale 1ns / 100ps

module rgb565_five_four_upscaler_checker
    import rgbup_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // fields from bit 0: pixel_a, pixel_b, pixel_c, pixel_d
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // fields from bit 0: out_first, out_blend, out_second, out_third,
    // out_fourth, dest_row, dest_group, zero pad
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    // run_last
    input  logic                  i_m_tlast,
    output int                    o_fail_count,
    output int                    o_pending
);

    // one destination beat of five pixels with its placement
    typedef struct packed {
        logic [PIX_W-1:0]     first;
        logic [PIX_W-1:0]     blend;
        logic [PIX_W-1:0]     second;
        logic [PIX_W-1:0]     third;
        logic [PIX_W-1:0]     fourth;
        logic [ROW_OUT_W-1:0] row;
        logic [GRP_OUT_W-1:0] grp;
        logic                 run_last;
    } upscaled_beat_t;

    upscaled_beat_t upscaled_q[$];

    // own copy of the frame position
    int         group_idx;
    int         row_idx;
    logic [1:0] src_phase;

    // work out the destination beats of one source group and move the counters on
    task automatic predict_upscaled(input logic [IN_DATA_W-1:0] group);
        upscaled_beat_t beat;
        logic           repeat_line;
        logic           twice;
        int             next_row;
        beat.first    = group[0*PIX_W +: PIX_W];
        beat.second   = group[1*PIX_W +: PIX_W];
        beat.third    = group[2*PIX_W +: PIX_W];
        beat.fourth   = group[3*PIX_W +: PIX_W];
        beat.blend    = (((beat.first ^ beat.second) & BLEND_MASK) >> 1)
                        + (beat.first & beat.second);
        repeat_line   = (src_phase == PHASE_REPEAT);
        twice         = repeat_line && (row_idx + 1 < DEST_ROWS);
        beat.row      = row_idx[ROW_OUT_W-1:0];
        beat.grp      = group_idx[GRP_OUT_W-1:0];
        beat.run_last = !twice;
        upscaled_q.push_back(beat);
        // repeated line goes to the next row as well, unless the frame ends here
        if (twice) begin
            next_row      = row_idx + 1;
            beat.row      = next_row[ROW_OUT_W-1:0];
            beat.run_last = 1'b1;
            upscaled_q.push_back(beat);
        end
        group_idx++;
        if (group_idx >= GROUPS_PER_LINE) begin
            group_idx = 0;
            row_idx   += repeat_line ? 2 : 1;
            src_phase = src_phase + 2'd1;
            if (row_idx >= DEST_ROWS) begin
                row_idx   = 0;
                src_phase = '0;
            end
        end
    endtask

    // watch both channels on every rising edge
    always @(posedge i_clk) begin
        upscaled_beat_t got;
        upscaled_beat_t want;
        if (!i_rst_n) begin
            group_idx    = 0;
            row_idx      = 0;
            src_phase    = '0;
            o_fail_count = 0;
            upscaled_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predict_upscaled(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.first    = i_m_tdata[0*PIX_W +: PIX_W];
                got.blend    = i_m_tdata[1*PIX_W +: PIX_W];
                got.second   = i_m_tdata[2*PIX_W +: PIX_W];
                got.third    = i_m_tdata[3*PIX_W +: PIX_W];
                got.fourth   = i_m_tdata[4*PIX_W +: PIX_W];
                got.row      = i_m_tdata[5*PIX_W +: ROW_OUT_W];
                got.grp      = i_m_tdata[5*PIX_W + ROW_OUT_W +: GRP_OUT_W];
                got.run_last = i_m_tlast;
                if (upscaled_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected beat: %h %h %h %h %h row %0d grp %0d last %b",
                                 got.first, got.blend, got.second, got.third, got.fourth,
                                 got.row, got.grp, got.run_last);
                    end
                    o_fail_count++;
                end else begin
                    want = upscaled_q.pop_front();
                    if (got.first !== want.first || got.blend !== want.blend ||
                        got.second !== want.second || got.third !== want.third ||
                        got.fourth !== want.fourth || got.row !== want.row ||
                        got.grp !== want.grp || got.run_last !== want.run_last) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch exp: %h %h %h %h %h row %0d grp %0d last %b",
                                     want.first, want.blend, want.second, want.third,
                                     want.fourth, want.row, want.grp, want.run_last);
                            $display("         got: %h %h %h %h %h row %0d grp %0d last %b",
                                     got.first, got.blend, got.second, got.third,
                                     got.fourth, got.row, got.grp, got.run_last);
                        end
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = upscaled_q.size();
    end

endmodule

// ===== test/rgb565_five_four_upscaler_tb.sv =====
`timescale 1ns / 100ps

module rgb565_five_four_upscaler_tb;
    import rgbup_pkg::*;

    // corner groups, pixel_a in the low bits
    localparam logic [IN_DATA_W-1:0] CORNER_GROUPS [16] = '{
        64'h0000_0000_0000_0000,
        64'hffff_ffff_ffff_ffff,
        64'h0000_ffff_0000_ffff,
        64'hffff_0000_ffff_0000,
        64'h001f_07e0_0800_f800,
        64'h0020_001f_0000_07e0,
        64'hf800_07e0_0001_001f,
        64'h0821_f7de_0821_f7de,
        64'hf7de_0821_f7de_0821,
        64'haaaa_5555_aaaa_5555,
        64'h5555_aaaa_5555_aaaa,
        64'h8000_0001_8000_7fff,
        64'h0001_8000_fffe_fffe,
        64'h1234_5678_ffff_fffe,
        64'hffff_0000_0821_0821,
        64'h0000_ffff_ffdf_ffff
    };

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata    = '0;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int cycle_limit = 32'h7fffffff;
    int stall_left  = 0;
    bit no_idle     = 1'b0;

    rgb565_five_four_upscaler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    rgb565_five_four_upscaler_checker beat_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 30);
    endfunction

    // pixel biased towards the extremes
    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return PIX_W'($urandom);
    endfunction

    // present one group after a random gap and hold it until taken
    task automatic send_group(input logic [IN_DATA_W-1:0] group);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= group;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("FAIL rgb565_five_four_upscaler");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        int random_items;
        // random groups after the directed corners, about 1050 in all
        random_items = 1050 - $size(CORNER_GROUPS);
        cycle_limit = (random_items + 16) * 400 + 10000;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        foreach (CORNER_GROUPS[i]) begin
            send_group(CORNER_GROUPS[i]);
        end

        // random groups with runs of back-to-back traffic now and then
        for (int n = 0; n < random_items; n++) begin
            if ($urandom_range(0, 149) == 0) begin
                no_idle = !no_idle;
            end
            send_group({pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel()});
        end
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        no_idle  = 1'b0;

        // drain, then watch for stray beats
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS rgb565_five_four_upscaler");
        end else begin
            $display("FAIL rgb565_five_four_upscaler");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rgbup_pkg.sv
rtl/rgbup_front.sv
rtl/rgbup_queue.sv
rtl/rgbup_back.sv
rtl/rgb565_five_four_upscaler.sv
test/rgb565_five_four_upscaler_checker.sv
test/rgb565_five_four_upscaler_tb.sv
